[design/fss_pkg.sv]
// ----------------------------------------------------------------------------
// fss_pkg: shared types, constants and helpers of the fuzzy subsequence scorer
// Holds the segment state record, the register indexes, the special characters
// and the small scoring functions used by the character unit and the top level.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int SCORE_W     = 12;
  localparam int CHAR_W      = 8;
  localparam int CNT_W       = 5;
  localparam int PAT_BITS    = 2 * 64;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 12'd4095;
  localparam logic [CNT_W-1:0]   POS_MAX   = 5'd31;
  localparam logic [CNT_W-1:0]   RUN_MAX   = 5'd31;

  localparam logic [7:0] BONUS_BASE     = 8'd1;
  localparam logic [7:0] BONUS_BOUNDARY = 8'd10;
  localparam logic [7:0] BONUS_FIRST    = 8'd8;
  localparam logic [7:0] BONUS_EXACT    = 8'd1;
  localparam logic [7:0] BONUS_FULL     = 8'd15;
  localparam logic [5:0] SHORT_SLACK    = 6'd2;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_WEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIST_MODE      = 3'd4;

  typedef struct packed {
    logic [CNT_W-1:0]   matched_count;
    logic [CNT_W-1:0]   run_length;
    logic [SCORE_W-1:0] running_score;
    logic [CHAR_W-1:0]  previous_char;
    logic [CNT_W-1:0]   char_position;
  } seg_state_t;

  function automatic logic is_upper(input logic [CHAR_W-1:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [CHAR_W-1:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic [CHAR_W-1:0] lower_of(input logic [CHAR_W-1:0] c);
    return is_upper(c) ? (c + 8'd32) : c;
  endfunction

  function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                 input logic [7:0] b);
    logic [SCORE_W:0] s;
    s = {1'b0, a} + {5'b0, b};
    return s[SCORE_W] ? SCORE_MAX : s[SCORE_W-1:0];
  endfunction

  // Score of a segment when it closes.
  function automatic logic [SCORE_W-1:0] seg_score(input seg_state_t seg,
                                                   input logic [CNT_W-1:0] plen);
    logic [5:0] short_lim;
    short_lim = {1'b0, plen} + SHORT_SLACK;
    if (plen == '0) begin
      return 12'd1;
    end else if (seg.char_position == '0 || seg.matched_count < plen) begin
      return '0;
    end else if ({1'b0, seg.char_position} <= short_lim) begin
      return sat_add(seg.running_score, BONUS_FULL);
    end else begin
      return seg.running_score;
    end
  endfunction

endpackage

[design/fss_char_unit.sv]
// ----------------------------------------------------------------------------
// fss_char_unit: one text character against the next pattern character
// Lower-cases the character, tests it against the next unmatched pattern
// character, adds the match bonuses and advances the segment state.
// ----------------------------------------------------------------------------
module fss_char_unit (
  input  fss_pkg::seg_state_t               seg_in,
  input  logic [fss_pkg::CHAR_W-1:0]        text_char,
  input  logic [fss_pkg::PAT_BITS-1:0]      pattern,
  input  logic [fss_pkg::CNT_W-1:0]         plen,
  input  logic                              list_mode,
  output fss_pkg::seg_state_t               seg_out
);
  import fss_pkg::*;

  logic [CHAR_W-1:0] low_c;
  logic [CHAR_W-1:0] orig_c;
  logic [CHAR_W-1:0] pat_c;
  logic              boundary;
  logic [7:0]        bonus;

  always_comb begin
    low_c  = lower_of(text_char);
    // List mode lower-cases before every use, boundary test included.
    orig_c = list_mode ? low_c : text_char;
    pat_c  = pattern[seg_in.matched_count[3:0]*CHAR_W +: CHAR_W];

    boundary = (seg_in.char_position == '0) ||
               (seg_in.previous_char == CH_SPACE) || (seg_in.previous_char == CH_DASH) ||
               (seg_in.previous_char == CH_UNDER) || (seg_in.previous_char == CH_DOT) ||
               (is_lower(seg_in.previous_char) && is_upper(orig_c));

    bonus = BONUS_BASE + {1'b0, seg_in.run_length, 2'b00};
    if (boundary) bonus = bonus + BONUS_BOUNDARY;
    if (seg_in.char_position == '0) bonus = bonus + BONUS_FIRST;
    if (orig_c == pat_c) bonus = bonus + BONUS_EXACT;

    seg_out = seg_in;
    if (seg_in.matched_count < plen) begin
      if (low_c == pat_c) begin
        seg_out.running_score = sat_add(seg_in.running_score, bonus);
        if (seg_in.run_length < RUN_MAX) seg_out.run_length = seg_in.run_length + 5'd1;
        seg_out.matched_count = seg_in.matched_count + 5'd1;
      end else begin
        seg_out.run_length = '0;
      end
    end
    seg_out.previous_char = orig_c;
    if (seg_in.char_position < POS_MAX) begin
      seg_out.char_position = seg_in.char_position + 5'd1;
    end
  end

endmodule

[design/fuzzy_subsequence_scorer.sv]
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer: streaming fuzzy match score of a text
// Scores a character stream against a configured lower-case pattern and
// reports one weighted score for each text.
// ----------------------------------------------------------------------------
// The block takes one text beat per clock cycle, every cycle, as long as the
// result side keeps up. An accepted beat sits in the input register and is
// scored there: the segment state (matched count, run length, running score,
// previous character, position) takes its new value at the edge at which the
// beat leaves the input register. That state loop is what sets the rate of one
// beat per cycle. A beat with text_end set loads its result into the output
// register at the same edge at which it leaves the input register, so out_valid
// rises when the text_end beat leaves the input register. Beats
// without text_end never wait on the result side; a text_end beat waits only
// while an earlier result is still untaken.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata and must
// only change while no text is in flight.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [fss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_text_char,
  input  logic                          in_char_present,
  input  logic                          in_text_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [11:0]                   out_match_score,
  output logic                          out_fully_matched
);
  import fss_pkg::*;

  // Configuration registers.
  logic [4:0]  pattern_length_r;
  logic [63:0] pattern_low_r;
  logic [63:0] pattern_high_r;
  logic [1:0]  score_weight_r;
  logic        list_mode_r;

  // Input register.
  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_present_r;
  logic              s1_end_r;

  // Scoring state.
  seg_state_t         seg_r, seg_nxt;
  logic [SCORE_W-1:0] best_r, best_nxt;

  // Output register.
  logic               out_valid_r;
  logic [SCORE_W-1:0] out_score_r, out_score_nxt;
  logic               out_full_r, out_full_nxt;

  logic               proc;
  logic [CNT_W-1:0]   plen;
  seg_state_t         seg_take;
  seg_state_t         seg_a;
  logic [SCORE_W-1:0] best_a;
  logic [SCORE_W-1:0] best_b;
  logic [SCORE_W-1:0] score_old;
  logic [SCORE_W-1:0] score_a;
  logic               is_semi;
  logic [13:0]        weighted;

  // The input beat moves on unless it ends a text and the result slot is full and not being taken.
  assign proc     = s1_valid_r && (!s1_end_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || proc;

  // Pattern lengths past the pattern storage are taken as the full pattern.
  assign plen = (pattern_length_r > CNT_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN)
                                                         : pattern_length_r;

  fss_char_unit u_char (
    .seg_in    (seg_r),
    .text_char (s1_char_r),
    .pattern   ({pattern_high_r, pattern_low_r}),
    .plen      (plen),
    .list_mode (list_mode_r),
    .seg_out   (seg_take)
  );

  always_comb begin
    is_semi   = list_mode_r && (s1_char_r == CH_SEMI);
    score_old = seg_score(seg_r, plen);

    // First the character itself: a semicolon in list mode closes the segment,
    // anything else present is scored.
    seg_a  = seg_r;
    best_a = best_r;
    if (s1_present_r) begin
      if (is_semi) begin
        seg_a = '0;
        if (seg_r.char_position != '0 && score_old > best_r) best_a = score_old;
      end else begin
        seg_a = seg_take;
      end
    end

    // Then the end of text closes the last segment; list mode skips it if empty.
    score_a = seg_score(seg_a, plen);
    best_b  = best_a;
    if ((!list_mode_r || seg_a.char_position != '0) && score_a > best_a) best_b = score_a;

    weighted      = {2'b00, best_b} * {12'b0, score_weight_r};
    out_score_nxt = (weighted > {2'b00, SCORE_MAX}) ? SCORE_MAX : weighted[SCORE_W-1:0];
    out_full_nxt  = (best_b != '0);

    seg_nxt  = seg_r;
    best_nxt = best_r;
    if (proc) begin
      if (s1_end_r) begin
        seg_nxt  = '0;
        best_nxt = '0;
      end else begin
        seg_nxt  = seg_a;
        best_nxt = best_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= '0;
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      score_weight_r   <= 2'd1;
      list_mode_r      <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_wdata[4:0];
        REG_PATTERN_LOW:    pattern_low_r    <= cfg_wdata;
        REG_PATTERN_HIGH:   pattern_high_r   <= cfg_wdata;
        REG_SCORE_WEIGHT:   score_weight_r   <= cfg_wdata[1:0];
        REG_LIST_MODE:      list_mode_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      seg_r       <= '0;
      best_r      <= '0;
    end else begin
      seg_r  <= seg_nxt;
      best_r <= best_nxt;
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (proc) begin
        s1_valid_r <= 1'b0;
      end
      if (proc && s1_end_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r    <= in_text_char;
      s1_present_r <= in_char_present;
      s1_end_r     <= in_text_end;
    end
    if (proc && s1_end_r) begin
      out_score_r <= out_score_nxt;
      out_full_r  <= out_full_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_match_score   = out_score_r;
  assign out_fully_matched = out_full_r;

  // A text end always leaves a clean slate for the next text.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && s1_end_r) |=> (best_r == '0 && seg_r == '0))
    else $error("scoring state not cleared after text end");

  // The run of consecutive matches never exceeds the matched count.
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seg_r.run_length <= seg_r.matched_count)
    else $error("run length above matched count");

  // Nothing is matched in a segment before its first character.
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (seg_r.char_position == '0) |-> (seg_r.matched_count == '0))
    else $error("match recorded in an empty segment");

  // A result without a match carries a zero score.
  a_zero_score: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_full_r) |-> (out_score_r == '0))
    else $error("nonzero score without a full match");

  // A result is never overwritten while it waits.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_score_r)))
    else $error("pending result lost");

endmodule

[tb/sv/fuzzy_subsequence_scorer_test.sv]
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer_test: self-checking bench of the fuzzy scorer
// Streams directed and random texts into the scorer while both sides idle and
// stall at random. A behavioral scoring model predicts one result per text,
// and every result beat is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer_test;
  import fss_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 52;
  localparam int SETTLE       = 4;
  localparam int PHASE_LEN    [8] = '{16, 1, 31, 5, 8, 0, 12, 3};
  localparam int PHASE_WEIGHT [8] = '{3, 1, 2, 3, 1, 2, 3, 1};

  typedef struct {
    logic [7:0] ch;
    logic       present;
    logic       last;
  } text_beat_t;

  typedef struct {
    logic [11:0] score;
    logic        matched;
  } text_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PATTERN_LENGTH;
  logic [63:0]          cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_text_char = '0;
  logic                 in_char_present = 1'b0;
  logic                 in_text_end = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [11:0]          out_match_score;
  logic                 out_fully_matched;

  fuzzy_subsequence_scorer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_text_char      (in_text_char),
    .in_char_present   (in_char_present),
    .in_text_end       (in_text_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_match_score   (out_match_score),
    .out_fully_matched (out_fully_matched)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Bookkeeping shared between the stimulus, the sender, the receiver and the
  // checker. The stimulus process only touches these right after a rising edge,
  // the sender and receiver work on the falling edge, so nothing races.
  text_beat_t   text_beats[$];
  text_result_t expected_scores[$];
  int           beats_queued = 0;
  int           beats_taken = 0;
  int           stim_items = 0;
  int           fail_count = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           holds_asked = 0;
  int           holds_served = 0;
  int           hold_left = 0;
  logic         in_taken = 1'b0;

  // Register copies used by the scoring model.
  logic [4:0]   cfg_plen = '0;
  logic [63:0]  cfg_pat_lo = '0;
  logic [63:0]  cfg_pat_hi = '0;
  logic [1:0]   cfg_weight = 2'd1;
  logic         cfg_list = 1'b0;

  // Segment state of the scoring model.
  logic [4:0]   seg_matched = '0;
  logic [4:0]   seg_run = '0;
  logic [11:0]  seg_score = '0;
  logic [7:0]   seg_prev = '0;
  logic [4:0]   seg_pos = '0;
  logic [11:0]  text_best = '0;

  // Pattern as the stimulus generator knows it, used to build matching texts.
  logic [7:0]   gen_pat [16];
  int           gen_len = 0;
  bit           gen_list = 1'b0;

  // --------------------------------------------------------------------------
  // Scoring model
  // --------------------------------------------------------------------------
  function automatic int unsigned capped(int unsigned v);
    return (v > 4095) ? 4095 : v;
  endfunction

  function automatic int unsigned pattern_in_use();
    return (cfg_plen > MAX_PATTERN) ? MAX_PATTERN : cfg_plen;
  endfunction

  function automatic logic [7:0] pattern_byte(int i);
    return (i < 8) ? cfg_pat_lo[8*i +: 8] : cfg_pat_hi[8*(i-8) +: 8];
  endfunction

  function automatic logic [7:0] folded(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // One text character of the current segment. In list mode the character is
  // lower-cased before every use, so the lower-to-upper boundary and the exact
  // case bonus both see the folded character.
  function automatic void take_text_char(logic [7:0] raw);
    logic [7:0]  low;
    logic [7:0]  seen;
    logic [7:0]  want;
    logic        boundary;
    int unsigned gain;
    low  = folded(raw);
    seen = cfg_list ? low : raw;
    if (seg_matched < pattern_in_use()) begin
      want = pattern_byte(seg_matched);
      if (low == want) begin
        boundary = (seg_pos == 0) || seg_prev == CH_SPACE || seg_prev == CH_DASH ||
                   seg_prev == CH_UNDER || seg_prev == CH_DOT ||
                   (seg_prev >= "a" && seg_prev <= "z" && seen >= "A" && seen <= "Z");
        gain = 1;
        gain += boundary ? 10 : 0;
        gain += 4 * seg_run;
        gain += (seg_pos == 0) ? 8 : 0;
        gain += (seen == want) ? 1 : 0;
        seg_score = 12'(capped(seg_score + gain));
        if (seg_run < 31) seg_run++;
        seg_matched++;
      end else begin
        seg_run = '0;
      end
    end
    seg_prev = seen;
    if (seg_pos < 31) seg_pos++;
  endfunction

  // Folds the finished segment into the best score of the text. Empty
  // segments are skipped in list mode only.
  function automatic void close_text_segment();
    int unsigned plen;
    int unsigned total;
    plen = pattern_in_use();
    if (!cfg_list || seg_pos != 0) begin
      if (plen == 0) begin
        total = 1;
      end else if (seg_pos == 0 || seg_matched < plen) begin
        total = 0;
      end else if (seg_pos <= plen + 2) begin
        total = capped(seg_score + 15);
      end else begin
        total = seg_score;
      end
      if (total > text_best) text_best = 12'(total);
    end
    seg_matched = '0;
    seg_run     = '0;
    seg_score   = '0;
    seg_prev    = '0;
    seg_pos     = '0;
  endfunction

  // Applies one accepted input beat and queues the text result on text end.
  function automatic void score_beat(logic [7:0] c, logic present, logic last);
    int unsigned  weighted;
    text_result_t res;
    if (present) begin
      if (cfg_list && c == CH_SEMI) close_text_segment();
      else take_text_char(c);
    end
    if (last) begin
      close_text_segment();
      weighted = 32'(text_best);
      weighted = capped(weighted * cfg_weight);
      res.score   = weighted[11:0];
      res.matched = (text_best != 0);
      expected_scores = {expected_scores, res};
      text_best = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offers the next queued beat at the falling edge once the previous
  // one was taken, or idles at random. Valid is held with a stable payload
  // until the scorer takes the beat.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : sender
    text_beat_t b;
    if (!in_valid || in_taken) begin
      if (text_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        b = text_beats.pop_front();
        in_valid        <= 1'b1;
        in_text_char    <= b.ch;
        in_char_present <= b.present;
        in_text_end     <= b.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request that lets the
  // output register fill and back pressure reach the input side.
  always @(negedge clk) begin : receiver
    if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left    <= LONG_HOLD;
      out_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Checker: feeds every accepted input beat to the model and compares every
  // accepted result beat with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    text_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fuzzy_subsequence_scorer_test NOT OK");
      $finish;
    end else if (rst_n) begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        score_beat(in_text_char, in_char_present, in_text_end);
        beats_taken <= beats_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_scores.size() == 0) begin
          $error("result beat with no text pending: match_score %0d, fully_matched %0b",
                 out_match_score, out_fully_matched);
          fail_count++;
        end else begin
          want = expected_scores.pop_front();
          if (out_match_score !== want.score) begin
            $error("match_score: expected %0d, got %0d", want.score, out_match_score);
            fail_count++;
          end
          if (out_fully_matched !== want.matched) begin
            $error("fully_matched: expected %0b, got %0b", want.matched, out_fully_matched);
            fail_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_beat(logic [7:0] ch, logic present, logic last);
    text_beat_t b;
    b.ch       = ch;
    b.present  = present;
    b.last     = last;
    text_beats = {text_beats, b};
    beats_queued++;
    // Absent beats without text end are ignored by the scorer.
    if (present || last) stim_items++;
  endfunction

  function automatic logic [7:0] filler_char();
    logic [7:0] seps [5];
    seps = '{CH_SPACE, CH_DASH, CH_UNDER, CH_DOT, CH_SEMI};
    case ($urandom_range(9))
      0, 1, 2, 3: return 8'(8'h61 + $urandom_range(25));
      4, 5:       return 8'(8'h41 + $urandom_range(25));
      6, 7:       return seps[$urandom_range(4)];
      default:    return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_PATTERN_LENGTH: cfg_plen   = data[4:0];
      REG_PATTERN_LOW:    cfg_pat_lo = data;
      REG_PATTERN_HIGH:   cfg_pat_hi = data;
      REG_SCORE_WEIGHT:   cfg_weight = data[1:0];
      REG_LIST_MODE:      cfg_list   = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Writes every register from the generator's pattern and the given settings.
  task automatic configure(int len, int weight, bit list);
    logic [63:0] lo;
    logic [63:0] hi;
    int          i;
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = gen_pat[i];
      hi[8*i +: 8] = gen_pat[i+8];
    end
    gen_len  = (len > MAX_PATTERN) ? MAX_PATTERN : len;
    gen_list = list;
    write_reg(REG_PATTERN_LENGTH, 64'(len));
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_SCORE_WEIGHT, 64'(weight));
    write_reg(REG_LIST_MODE, 64'(list));
  endtask

  // Unused pattern bytes are random so that every register bit toggles.
  function automatic void set_pattern_text(string s);
    int i;
    for (i = 0; i < 16; i++) begin
      gen_pat[i] = (i < s.len()) ? s[i] : 8'($urandom_range(255));
    end
  endfunction

  function automatic void random_pattern(int len);
    int i;
    for (i = 0; i < 16; i++) begin
      if (i >= len) gen_pat[i] = 8'($urandom_range(255));
      else if ($urandom_range(19) == 0) gen_pat[i] = 8'("0" + $urandom_range(9));
      else gen_pat[i] = 8'(8'h61 + $urandom_range(25));
    end
  endfunction

  task automatic queue_word(string s);
    int i;
    @(posedge clk);
    for (i = 0; i < s.len(); i++) push_beat(s[i], 1'b1, i == s.len() - 1);
  endtask

  // Builds one text. Most texts carry the whole pattern as a subsequence with
  // random fillers and case; the rest are partial matches or random bytes.
  // In list mode extra segments are wrapped around the matching part.
  task automatic queue_text();
    logic [7:0] txt [$];
    logic [7:0] c;
    int         kind;
    int         upto;
    int         k;
    bit         end_on_char;
    kind = $urandom_range(99);
    if (gen_list && $urandom_range(3) == 0) begin
      repeat ($urandom_range(3)) txt = {txt, filler_char()};
      txt = {txt, CH_SEMI};
    end
    if (kind < 80) begin
      upto = (kind < 65) ? gen_len : $urandom_range(gen_len);
      for (k = 0; k < upto; k++) begin
        if ($urandom_range(3) == 0) txt = {txt, filler_char()};
        c = gen_pat[k];
        if (c >= "a" && c <= "z" && $urandom_range(1) == 1) c = c - 8'd32;
        txt = {txt, c};
      end
      // Now and then run past the saturating character position.
      if ($urandom_range(19) == 0) repeat (30) txt = {txt, filler_char()};
      else repeat ($urandom_range(2)) txt = {txt, filler_char()};
    end else begin
      repeat ($urandom_range(12)) txt = {txt, 8'($urandom_range(255))};
    end
    if (gen_list && $urandom_range(3) == 0) begin
      txt = {txt, CH_SEMI};
      repeat ($urandom_range(3)) txt = {txt, filler_char()};
    end
    end_on_char = (txt.size() != 0) && ($urandom_range(1) == 1);
    @(posedge clk);
    for (k = 0; k < txt.size(); k++) begin
      if ($urandom_range(19) == 0) push_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      push_beat(txt[k], 1'b1, end_on_char && k == txt.size() - 1);
    end
    if (!end_on_char) push_beat(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Waits until every queued beat went in and every result came out, then
  // lets the pipeline drain past any trailing beats that cause no result.
  task automatic wait_idle();
    do @(negedge clk);
    while (beats_taken != beats_queued || expected_scores.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_idling(int mode);
    @(posedge clk);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 62; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 62; end
      default: begin send_idle_pct = 26; recv_stall_pct = 26; end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int ph;
    int target;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Three-letter pattern: mixed case with a lower-to-upper step, extreme
    // bytes in a text just short enough for the short bonus, an ignored absent beat,
    // and an empty text that cannot match.
    set_pattern_text("abc");
    configure(3, 3, 1'b0);
    queue_word("aBc");
    @(posedge clk);
    push_beat(8'h5A, 1'b0, 1'b0);
    push_beat(8'hFF, 1'b1, 1'b0);
    push_beat(8'h00, 1'b1, 1'b0);
    queue_word("abc");
    @(posedge clk);
    push_beat(8'hA5, 1'b0, 1'b1);
    wait_idle();

    // Empty pattern on an empty text scores one; a zero weight hides the
    // score but still reports the match; an upper-case pattern never matches.
    set_pattern_text("");
    configure(0, 1, 1'b0);
    @(posedge clk);
    push_beat(8'h3B, 1'b0, 1'b1);
    wait_idle();
    write_reg(REG_SCORE_WEIGHT, 64'd0);
    queue_word("z");
    wait_idle();
    set_pattern_text("Z");
    configure(1, 2, 1'b0);
    queue_word("Z");
    wait_idle();

    // List mode: folded case, empty segments, a text of nothing but a
    // separator, and a dash boundary.
    set_pattern_text("ab");
    configure(2, 2, 1'b1);
    queue_word("Ab;;xab");
    queue_word(";");
    queue_word("a-b");
    wait_idle();

    // Random phases over several pattern lengths (including an over-long
    // length register), weights, both modes and all idling profiles. Each
    // phase stops halfway until every result is back.
    for (ph = 0; ph < 8; ph++) begin
      random_pattern(PHASE_LEN[ph]);
      configure(PHASE_LEN[ph], PHASE_WEIGHT[ph], ph % 2);
      set_idling(ph % 4);
      // In one of the phases without random idling the receiver holds off for a
      // long stretch while texts keep coming, so the scorer backs up.
      if (ph == 4) holds_asked++;
      target = stim_items + PHASE_ITEMS / 2;
      while (stim_items < target) queue_text();
      wait_idle();
      target = stim_items + PHASE_ITEMS / 2;
      while (stim_items < target) queue_text();
      wait_idle();
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("fuzzy_subsequence_scorer_test OK");
    end else begin
      $display("fuzzy_subsequence_scorer_test NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
design/fss_pkg.sv
design/fss_char_unit.sv
design/fuzzy_subsequence_scorer.sv
tb/sv/fuzzy_subsequence_scorer_test.sv
